### sv/sws_pkg.sv
// Shared types and constants for the sliding window sender.
// No dependencies; imported by sws_stamp_mem, sws_out, sws_seq and sliding_window_sender.
package sws_pkg;

	localparam int ID_W   = 8;
	localparam int SEQ_W  = 16;
	localparam int CNT_W  = 17;
	localparam int WIN_W  = 5;
	localparam int TICK_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_ACK   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SENDER_ID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   sender_id;
		logic [SEQ_W-1:0]  total_frames;
		logic [WIN_W-1:0]  window_size;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic             frame_valid;
		logic [SEQ_W-1:0] frame_seq;
		logic             is_retransmit;
		logic             last;
		logic             transfer_done;
	} beat_t;

endpackage

### sv/sws_stamp_mem.sv
// Send-time stamp memory: one write port, one registered read port.
// Uses sws_pkg for the stamp width.
module sws_stamp_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [sws_pkg::TICK_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr,
	output logic [sws_pkg::TICK_W-1:0] rd_data
);
	import sws_pkg::*;

	logic [TICK_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### sv/sws_out.sv
// Output register for result beats; decouples the sequencer from the sink.
// Uses sws_pkg::beat_t.
module sws_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sws_pkg::beat_t      push_beat,
	output logic                can_push,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,   // frame_seq[15:0], transfer_done[16], zero pad
	output logic [1:0]          m_tuser,   // frame_valid[0], is_retransmit[1]
	output logic                m_tlast
);
	import sws_pkg::*;

	logic  valid_q;
	beat_t beat_q;

	assign can_push = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push) begin
			beat_q <= push_beat;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'b0, beat_q.transfer_done, beat_q.frame_seq};
	assign m_tuser  = {beat_q.is_retransmit, beat_q.frame_valid};
	assign m_tlast  = beat_q.last;

endmodule

### sv/sws_seq.sv
// Sender sequencer: window pointers, tick counter and the per-item step sequence.
// Uses sws_pkg; drives sws_stamp_mem and sws_out.
module sws_seq #(
	parameter int MAX_WINDOW = 16,
	parameter int SEQ_BITS   = 16,
	parameter int IDX_W      = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sws_pkg::cfg_t              cfg,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [1:0]                 command,
	input  logic [sws_pkg::ID_W-1:0]   ack_sender_id,
	input  logic [sws_pkg::SEQ_W-1:0]  ack_seq,
	input  logic                       can_push,
	output logic                       push,
	output sws_pkg::beat_t             push_beat,
	output logic                       wr_en,
	output logic [IDX_W-1:0]           wr_addr,
	output logic [sws_pkg::TICK_W-1:0] wr_data,
	output logic [IDX_W-1:0]           rd_addr,
	input  logic [sws_pkg::TICK_W-1:0] rd_data
);
	import sws_pkg::*;

	localparam int SEQ_EFF = (SEQ_BITS < SEQ_W) ? SEQ_BITS : SEQ_W;
	localparam logic [SEQ_W-1:0] SEQ_MASK = SEQ_W'((64'd1 << SEQ_EFF) - 64'd1);
	localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WINDOW);
	localparam logic [IDX_W:0] DEPTH_X = (IDX_W+1)'(MAX_WINDOW);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ACK  = 8'b0000_0010,
		S_ADV  = 8'b0000_0100,
		S_SEND = 8'b0000_1000,
		S_RD   = 8'b0001_0000,
		S_CMP  = 8'b0010_0000,
		S_RETX = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  oldest_q, next_q, f_q;
	logic [IDX_W-1:0]  oldest_idx_q, next_idx_q, f_idx_q;
	logic [IDX_W:0]    delta_q;
	logic [TICK_W-1:0] tick_q;
	logic [SEQ_W-1:0]  ack_q;
	logic              held_v_q;
	beat_t             held_q;

	logic [CNT_W-1:0]  win, nxt, nxt_c;
	logic [IDX_W:0]    adv_sum;
	logic [TICK_W-1:0] elapsed;
	logic              send_ok, retx_ok, emit, fin, done, id_ok;
	beat_t             new_beat, status_beat;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		logic [IDX_W:0] s;
		s = {1'b0, i} + 1'b1;
		return (s == DEPTH_X) ? '0 : s[IDX_W-1:0];
	endfunction

	always_comb begin
		if (cfg.window_size == '0) begin
			win = CNT_W'(1);
		end else if (CNT_W'(cfg.window_size) > MAXW) begin
			win = MAXW;
		end else begin
			win = CNT_W'(cfg.window_size);
		end
	end

	// cumulative ack points one past the acknowledged frame, clamped to next_q
	assign nxt     = {1'b0, ack_q} + 1'b1;
	assign nxt_c   = (nxt > next_q) ? next_q : nxt;
	assign adv_sum = {1'b0, oldest_idx_q} + delta_q;
	assign elapsed = tick_q - rd_data;

	assign done    = oldest_q >= CNT_W'(cfg.total_frames);
	assign send_ok = (next_q < CNT_W'(cfg.total_frames)) && ((next_q - oldest_q) < win);
	assign retx_ok = f_q < next_q;
	assign emit    = can_push && (((state_q == S_SEND) && send_ok)
		|| ((state_q == S_RETX) && retx_ok));
	assign fin     = can_push && (state_q == S_FIN);
	assign id_ok   = ack_sender_id == cfg.sender_id;

	always_comb begin
		new_beat.frame_valid   = 1'b1;
		new_beat.frame_seq     = ((state_q == S_RETX) ? f_q[SEQ_W-1:0] : next_q[SEQ_W-1:0])
			& SEQ_MASK;
		new_beat.is_retransmit = (state_q == S_RETX);
		new_beat.last          = 1'b0;
		new_beat.transfer_done = done;

		status_beat = '0;
		status_beat.last          = 1'b1;
		status_beat.transfer_done = done;

		// one result is held back until we know whether it closes the item
		push      = (emit && held_v_q) || fin;
		push_beat = held_q;
		push_beat.last = fin;
		if (fin && !held_v_q) begin
			push_beat = status_beat;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign wr_en    = emit;
	assign wr_addr  = (state_q == S_RETX) ? f_idx_q : next_idx_q;
	assign wr_data  = tick_q;
	assign rd_addr  = oldest_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			oldest_q     <= '0;
			next_q       <= '0;
			oldest_idx_q <= '0;
			next_idx_q   <= '0;
			tick_q       <= '0;
			held_v_q     <= 1'b0;
		end else begin
			if (emit) begin
				held_v_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (command == CMD_TICK) begin
							tick_q  <= tick_q + 1'b1;
							state_q <= S_RD;
						end else if (command == CMD_START && id_ok) begin
							state_q <= S_SEND;
						end else if (command == CMD_ACK && id_ok) begin
							state_q <= S_ACK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_ACK: begin
					if (nxt_c > oldest_q) begin
						oldest_q <= nxt_c;
					end
					state_q <= S_ADV;
				end
				S_ADV: begin
					oldest_idx_q <= (adv_sum >= DEPTH_X) ? IDX_W'(adv_sum - DEPTH_X)
						: adv_sum[IDX_W-1:0];
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (!send_ok) begin
						state_q <= S_RD;
					end else if (emit) begin
						next_q     <= next_q + 1'b1;
						next_idx_q <= idx_inc(next_idx_q);
					end
				end
				S_RD: begin
					state_q <= (oldest_q < next_q) ? S_CMP : S_FIN;
				end
				S_CMP: begin
					state_q <= (elapsed > cfg.timeout_ticks) ? S_RETX : S_FIN;
				end
				S_RETX: begin
					if (!retx_ok) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (can_push) begin
						held_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			ack_q <= ack_seq & SEQ_MASK;
		end
		if (state_q == S_ACK) begin
			delta_q <= (nxt_c > oldest_q) ? (IDX_W+1)'(nxt_c - oldest_q) : '0;
		end
		if (state_q == S_CMP) begin
			f_q     <= oldest_q;
			f_idx_q <= oldest_idx_q;
		end else if (state_q == S_RETX && emit) begin
			f_q     <= f_q + 1'b1;
			f_idx_q <= idx_inc(f_idx_q);
		end
		if (emit) begin
			held_q <= new_beat;
		end
	end

endmodule

### sv/sliding_window_sender.sv
// Go-back-N sender control. An item is taken when s_tready is high (sequencer idle) and
// yields one or more result beats, the final one flagged by m_tlast. A foreign start or
// ack, or an unused command, goes straight to the closing status step. A tick reads the
// oldest stamp when a frame is outstanding, compares its age with the timeout and on expiry
// resends every outstanding frame; a start first sends new frames within the window and
// then runs the same check, and a cumulative ack first updates the oldest pointer and index.
// A beat that m_tready holds back stalls the sequencer. Frames are issued at one per cycle
// while the output can take them, through the single write port of the stamp memory. The
// stamp memory has no clearing pass; the block is ready right after reset.
// Depends on sws_pkg, sws_seq, sws_stamp_mem and sws_out.
module sliding_window_sender #(
	parameter int MAX_WINDOW = 16,
	parameter int SEQ_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,   // ack_sender_id[7:0], ack_seq[23:8]
	input  logic [1:0]                        s_tuser,   // command[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,   // frame_seq[15:0], transfer_done[16]
	output logic [1:0]                        m_tuser,   // frame_valid[0], is_retransmit[1]
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sws_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sws_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sws_pkg::*;

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	cfg_t              cfg_q;
	logic              can_push, push, wr_en;
	beat_t             push_beat;
	logic [IDX_W-1:0]  wr_addr, rd_addr;
	logic [TICK_W-1:0] wr_data, rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sender_id     <= '0;
			cfg_q.total_frames  <= SEQ_W'(1);
			cfg_q.window_size   <= WIN_W'(4);
			cfg_q.timeout_ticks <= TICK_W'(1000);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SENDER_ID:     cfg_q.sender_id     <= cfg_data[ID_W-1:0];
				REG_TOTAL_FRAMES:  cfg_q.total_frames  <= cfg_data[SEQ_W-1:0];
				REG_WINDOW_SIZE:   cfg_q.window_size   <= cfg_data[WIN_W-1:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	sws_seq #(
		.MAX_WINDOW (MAX_WINDOW),
		.SEQ_BITS   (SEQ_BITS),
		.IDX_W      (IDX_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.command       (s_tuser),
		.ack_sender_id (s_tdata[7:0]),
		.ack_seq       (s_tdata[23:8]),
		.can_push      (can_push),
		.push          (push),
		.push_beat     (push_beat),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	sws_stamp_mem #(
		.DEPTH (MAX_WINDOW),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sws_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.can_push  (can_push),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

### sv/sws_checker.sv
// Port-level checks for sliding_window_sender, attached by bind.
// No package dependency.
module sws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	// the sequencer is busy the cycle after it takes an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// a status beat only closes an item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("status beat without tlast");

	// a status beat carries no frame number and no resend flag
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[15:0] == 16'd0) && !m_tuser[1])
		else $error("status beat carries frame fields");

endmodule

bind sliding_window_sender sws_checker u_sws_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

### sim/sliding_window_sender_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the go-back-N sender: directed window, clamp and timeout cases,
// then phases of random settings, starts, acks and ticks under random stalls. Needs sws_pkg and the RTL.
module sliding_window_sender_test;
	import sws_pkg::*;

	localparam int WIN_MAX = 16;
	localparam int WIN_IDX_W = $clog2(WIN_MAX);
	localparam int SEQ_LEN = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;   // ack_sender_id[7:0], ack_seq[23:8]
	logic [1:0]            s_tuser;   // command[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;   // frame_seq[15:0], transfer_done[16]
	logic [1:0]            m_tuser;   // frame_valid[0], is_retransmit[1]
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// sender state mirror
	logic [7:0]       own_id = 8'd0;
	logic [15:0]      msg_frames = 16'd1;
	logic [4:0]       win_cfg = 5'd4;
	logic [31:0]      tmo_cfg = 32'd1000;
	logic [CNT_W-1:0] oldest_open = '0;
	logic [CNT_W-1:0] next_new = '0;
	logic [31:0]      tick_now = '0;
	logic [31:0]      stamp [WIN_MAX];

	beat_t frames_due[$];
	int    faults = 0;
	int    tx_quiet = 0;
	int    rx_quiet = 0;

	sliding_window_sender #(
		.MAX_WINDOW(WIN_MAX),
		.SEQ_BITS(SEQ_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Mostly short gaps, a few long ones, and now and then a stretch with none.
	function automatic int gap_len(inout int quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if (r < 4) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Frames issued for one accepted item: new sends, then a go-back-N resend on timeout.
	task automatic predict_frames(input logic [1:0] cmd, input logic [7:0] id,
			input logic [15:0] ack);
		beat_t            burst[$];
		logic [31:0]      upto;
		logic [CNT_W-1:0] f;
		int unsigned      win;
		logic             go;
		logic             done;
		go = 1'b1;
		if (cmd == CMD_TICK) begin
			tick_now = tick_now + 32'd1;
		end else if ((cmd != CMD_START && cmd != CMD_ACK) || id != own_id) begin
			go = 1'b0;
		end else begin
			if (cmd == CMD_ACK) begin
				upto = {16'd0, ack} + 32'd1;
				if (upto > 32'(next_new)) upto = 32'(next_new);
				if (upto > 32'(oldest_open)) oldest_open = upto[CNT_W-1:0];
			end
			win = (win_cfg == 0) ? 1 : (win_cfg > WIN_MAX) ? WIN_MAX : win_cfg;
			while (next_new < msg_frames && next_new - oldest_open < win) begin
				stamp[WIN_IDX_W'(next_new % WIN_MAX)] = tick_now;
				burst.push_back('{frame_valid: 1'b1, frame_seq: next_new[SEQ_LEN-1:0],
					is_retransmit: 1'b0, last: 1'b0, transfer_done: 1'b0});
				next_new++;
			end
		end
		if (go && oldest_open < next_new) begin
			if (tick_now - stamp[WIN_IDX_W'(oldest_open % WIN_MAX)] > tmo_cfg) begin
				for (f = oldest_open; f < next_new; f++) begin
					stamp[WIN_IDX_W'(f % WIN_MAX)] = tick_now;
					burst.push_back('{frame_valid: 1'b1, frame_seq: f[SEQ_LEN-1:0],
						is_retransmit: 1'b1, last: 1'b0, transfer_done: 1'b0});
				end
			end
		end
		done = (oldest_open >= msg_frames);
		if (burst.size() == 0)
			burst.push_back('{frame_valid: 1'b0, frame_seq: '0, is_retransmit: 1'b0,
				last: 1'b0, transfer_done: 1'b0});
		foreach (burst[i]) begin
			burst[i].transfer_done = done;
			burst[i].last = (i == burst.size() - 1);
			frames_due.push_back(burst[i]);
		end
	endtask

	task automatic send_item(input logic [1:0] cmd, input logic [7:0] id,
			input logic [15:0] seq);
		int g;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {seq, id};
		do @(posedge clk); while (!s_tready);
		predict_frames(cmd, id, seq);
		g = gap_len(tx_quiet);
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain_frames();
		while (frames_due.size() != 0) @(posedge clk);
	endtask

	// cfg_valid is held by the caller across consecutive writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SENDER_ID: own_id = val[7:0];
			REG_TOTAL_FRAMES: msg_frames = val[15:0];
			REG_WINDOW_SIZE: win_cfg = val[4:0];
			REG_TIMEOUT_TICKS: tmo_cfg = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [31:0] id_v, input logic [31:0] total_v,
			input logic [31:0] win_v, input logic [31:0] tmo_v);
		s_tvalid <= 1'b0;
		drain_frames();
		cfg_valid <= 1'b1;
		write_reg(REG_SENDER_ID, id_v);
		write_reg(REG_TOTAL_FRAMES, total_v);
		write_reg(REG_WINDOW_SIZE, win_v);
		write_reg(REG_TIMEOUT_TICKS, tmo_v);
		cfg_valid <= 1'b0;
	endtask

	// Reset settings: one frame, window 4.
	task automatic test_first_frame();
		send_item(CMD_TICK, 8'd0, 16'd0);
		send_item(CMD_START, 8'd0, 16'd0);
		send_item(CMD_START, 8'd0, 16'd0);
		send_item(CMD_ACK, 8'd5, 16'd0);
		send_item(CMD_UNUSED, 8'd0, 16'd0);
		send_item(CMD_ACK, 8'd0, 16'd0);
	endtask

	// Window 0 behaves as 1, 31 as 16; an ack past the last sent frame is clamped,
	// a stale one is ignored.
	task automatic test_window_bounds();
		load_settings(32'd255, 32'd40, 32'd0, 32'hFFFF_FFFF);
		send_item(CMD_START, 8'd255, 16'd0);
		load_settings(32'd255, 32'd40, 32'd31, 32'hFFFF_FFFF);
		send_item(CMD_ACK, 8'd255, 16'd1);
		send_item(CMD_ACK, 8'd255, 16'hFFFF);
		send_item(CMD_ACK, 8'd255, 16'd0);
	endtask

	task automatic test_timeouts();
		send_item(CMD_ACK, 8'd255, 16'd32);
		send_item(CMD_TICK, 8'd255, 16'd0);
		send_item(CMD_TICK, 8'd0, 16'hFFFF);
		// oldest frame is now overdue; foreign and unused commands must not resend
		load_settings(32'd255, 32'd60, 32'd16, 32'd0);
		send_item(CMD_START, 8'd7, 16'd0);
		send_item(CMD_UNUSED, 8'd255, 16'd0);
		send_item(CMD_START, 8'd255, 16'd0);
		send_item(CMD_TICK, 8'd0, 16'd0);
		// resend only once elapsed exceeds the limit, not when it equals it
		load_settings(32'd255, 32'd60, 32'd16, 32'd3);
		repeat (4) send_item(CMD_TICK, 8'd0, 16'd0);
	endtask

	task automatic test_random_traffic();
		int          counted;
		int          r;
		int          lo;
		int          hi;
		int          want_total;
		logic [7:0]  id_v;
		logic [15:0] total_v;
		logic [4:0]  win_v;
		logic [31:0] tmo_v;
		logic [31:0] junk;
		logic [1:0]  cmd;
		logic [7:0]  id;
		logic [15:0] seq;
		counted = 0;
		while (counted < 200) begin
			r = $urandom_range(0, 99);
			id_v = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom());
			r = $urandom_range(0, 99);
			if (r < 5) begin
				total_v = 16'd0;
			end else if (r < 10) begin
				total_v = 16'hFFFF;
			end else if (r < 20) begin
				total_v = 16'($urandom_range(0, next_new));
			end else begin
				want_total = int'(next_new) + int'($urandom_range(4, 120));
				total_v = (want_total > 65535) ? 16'hFFFF : 16'(want_total);
			end
			r = $urandom_range(0, 99);
			win_v = (r < 10) ? 5'd0 : (r < 20) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(1, 16));
			r = $urandom_range(0, 99);
			if (r < 30) tmo_v = $urandom_range(0, 3);
			else if (r < 60) tmo_v = $urandom_range(4, 30);
			else if (r < 80) tmo_v = 32'hFFFF_FFFF;
			else tmo_v = $urandom();
			junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
			load_settings({junk[31:8], id_v}, {junk[31:16], total_v}, {junk[31:5], win_v},
				tmo_v);
			repeat ($urandom_range(10, 40)) begin
				if (counted >= 200) break;
				if ($urandom_range(0, 99) < 3 && frames_due.size() != 0) begin
					s_tvalid <= 1'b0;
					drain_frames();
				end
				r = $urandom_range(0, 99);
				id = own_id;
				seq = 16'($urandom());
				if (r < 30) begin
					cmd = CMD_TICK;
					id = 8'($urandom());
				end else if (r < 40) begin
					cmd = CMD_START;
				end else if (r < 70) begin
					cmd = CMD_ACK;
					lo = (oldest_open >= 2) ? int'(oldest_open) - 2 : 0;
					hi = (next_new > 65535) ? 65535 : int'(next_new);
					seq = 16'($urandom_range(lo, hi));
				end else if (r < 76) begin
					cmd = CMD_ACK;
				end else if (r < 80) begin
					cmd = CMD_ACK;
					seq = (next_new == 0) ? 16'd0 : 16'(next_new - 1);
				end else if (r < 92) begin
					cmd = $urandom_range(0, 1) ? CMD_START : CMD_ACK;
					id = 8'($urandom());
					if (id == own_id) id = id ^ 8'h01;
				end else begin
					cmd = CMD_UNUSED;
					id = 8'($urandom());
				end
				send_item(cmd, id, seq);
				counted++;
			end
		end
	endtask

	initial begin
		int hold;
		hold = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) hold--;
			else hold = gap_len(rx_quiet);
			m_tready <= (hold == 0);
		end
	end

	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{frame_valid: m_tuser[0], frame_seq: m_tdata[15:0],
				is_retransmit: m_tuser[1], last: m_tlast, transfer_done: m_tdata[16]};
			if (frames_due.size() == 0) begin
				if (faults < 10)
					$display("unexpected beat: valid=%0b seq=%0d retx=%0b last=%0b done=%0b",
						got.frame_valid, got.frame_seq, got.is_retransmit, got.last,
						got.transfer_done);
				faults++;
			end else begin
				want = frames_due.pop_front();
				if (got !== want) begin
					if (faults < 10) begin
						$write("beat mismatch: expected valid=%0b seq=%0d retx=%0b last=%0b done=%0b",
							want.frame_valid, want.frame_seq, want.is_retransmit, want.last,
							want.transfer_done);
						$display(", got valid=%0b seq=%0d retx=%0b last=%0b done=%0b",
							got.frame_valid, got.frame_seq, got.is_retransmit, got.last,
							got.transfer_done);
					end
					faults++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_TICK;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SENDER_ID;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_first_frame();
		test_window_bounds();
		test_timeouts();
		test_random_traffic();
		s_tvalid <= 1'b0;
		drain_frames();
		// catch stray beats after the last expected one
		repeat (30) @(posedge clk);
		if (faults == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### sliding_window_sender.f
sv/sws_pkg.sv
sv/sws_stamp_mem.sv
sv/sws_out.sv
sv/sws_seq.sv
sv/sliding_window_sender.sv
sv/sws_checker.sv
sim/sliding_window_sender_test.sv
